FILE: src/gcf_pkg.sv
// Shared types and constants for the gravity complementary filter.
// Depends on nothing; used by gravity_complementary_filter.
package gcf_pkg;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_RATE_M, S_RATE_A, S_ANG_M, S_ANG_A,
    S_CR1_M, S_CR1_A, S_CR2_M, S_CR2_A,
    S_NSHIFT, S_SQ_M, S_SQ_A, S_CHECK, S_SQRT,
    S_DIV_INIT, S_DIV, S_DIV_END, S_NDONE,
    S_BL1_M, S_BL1_A, S_BL2_M, S_BL2_A,
    S_VM, S_VA, S_OUT
  } state_t;

  // What the normalize routine is working on
  typedef enum logic [1:0] {
    NM_PRED, NM_ACCEL, NM_BLEND
  } norm_mode_t;

  // Register map (index = paddr[3:2])
  typedef enum logic [1:0] {
    REG_INIT_X, REG_INIT_Y, REG_INIT_Z, REG_GRAV_MAG
  } reg_idx_t;

  localparam logic signed [32:0] DEG2RAD_Q32  = 33'sd74961321;
  localparam logic [30:0]        W_NEAR_1G    = 31'd1020054733;
  localparam logic [30:0]        W_DEFAULT    = 31'd1052266988;
  localparam logic [30:0]        ONE_Q30      = 31'd1073741824;
  localparam logic signed [65:0] TENTH_SQ_Q60 = 66'sd11529215046068469;
  localparam logic signed [65:0] TENTH_SQ_Q32 = 66'sd42949672;
  localparam logic signed [65:0] EIGHT_SQ_Q32 = 66'sd274877906944;
  localparam logic signed [65:0] TWELVE_SQ_Q32 = 66'sd618475290624;
  localparam logic signed [43:0] LIM31_POS    = 44'sd2147483648;
  localparam logic signed [43:0] LIM31_NEG    = -44'sd2147483648;
  localparam logic [4:0]         SQRT_LAST    = 5'd31;
  localparam logic [4:0]         DIV_LAST     = 5'd30;
  localparam logic [1:0]         IDX_LAST     = 2'd2;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7fffffff;
    else if (x < -66'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

FILE: src/gravity_complementary_filter.sv
// Gravity complementary filter: sequencer around one shared multiplier,
// a bit-serial square root and a bit-serial divider. Uses gcf_pkg.
//
// Usage: one request on the input channel (accel, gyro, time_step) gives
// one request on the output channel (est_x/y/z, vertical_accel). An input
// request is taken when in_valid is high and in_stall low; in_stall is low
// only while the sequencer is idle, so one request is worked on at a time.
// Each normalization runs a 32-step square root once, then a divider
// pass per component; an oversized prediction is first halved until
// it fits. Products use the shared 33x33 multiplier, all in series.
// The next request is taken in the idle state that the sequencer
// enters once the result is loaded into the output register.
// The result sits in an output register until out_valid and !out_stall;
// a new input request can be taken while it waits, and the sequencer holds
// its last state until the output register is free. A stalled receiver
// only delays the next result. Reset (rst, synchronous) clears the handshake
// and restores the registers and the estimate to 0, 0, 1.0 (Q2.30) and the
// gravity magnitude to 642689 (9.80665 in Q15.16). The APB port writes the
// init registers (each also loads that estimate component) and the gravity
// magnitude; it should be written only while the block is idle.
module gravity_complementary_filter (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  input  logic signed [31:0] gyro_x,
  input  logic signed [31:0] gyro_y,
  input  logic signed [31:0] gyro_z,
  input  logic [23:0]        time_step,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] est_x,
  output logic signed [31:0] est_y,
  output logic signed [31:0] est_z,
  output logic signed [31:0] vertical_accel,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gcf_pkg::state_t     state, state_next;
  gcf_pkg::norm_mode_t mode;

  // configuration registers
  logic signed [31:0] init_x, init_y, init_z;
  logic [30:0]        grav_mag;

  // working registers
  logic signed [31:0] acc_in [3];
  logic signed [31:0] gyro   [3];
  logic [23:0]        dt;
  logic signed [31:0] est    [3];
  logic signed [30:0] ang    [3];
  logic signed [43:0] work   [3];
  logic signed [31:0] pred   [3];
  logic signed [31:0] unit_a [3];
  logic signed [65:0] acc;
  logic signed [65:0] prod;
  logic [1:0]         idx;
  logic [4:0]         cnt;
  logic               big;
  logic               near_1g;

  // square root and divider
  logic [63:0] sq_n;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [32:0] dv_rem;
  logic [30:0] dv_q;
  logic [30:0] dv_dsh;
  logic        dv_neg;

  logic cfg_wr;
  logic out_free;
  logic [1:0] idx_j, idx_k;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic v_big;
  logic [35:0] sq_rem_t, sq_trial_sub;
  logic        sq_take;
  logic [33:0] dv_rem_t;
  logic        dv_take;
  logic signed [32:0] abs_src;
  logic [31:0] dv_mag;
  logic signed [31:0] dv_result;
  logic signed [65:0] cross_diff, cross_sh, blend_sum, vert_wide;
  logic [30:0] w_sel, w_rest;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign in_stall = (state != gcf_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Register read back
  always_comb begin
    unique case (gcf_pkg::reg_idx_t'(paddr[3:2]))
      gcf_pkg::REG_INIT_X:   prdata = init_x;
      gcf_pkg::REG_INIT_Y:   prdata = init_y;
      gcf_pkg::REG_INIT_Z:   prdata = init_z;
      gcf_pkg::REG_GRAV_MAG: prdata = {1'b0, grav_mag};
      default:               prdata = '0;
    endcase
  end

  // Cross-product neighbor indexes
  assign idx_j = (idx == gcf_pkg::IDX_LAST) ? 2'd0 : idx + 2'd1;
  assign idx_k = (idx == 2'd0) ? gcf_pkg::IDX_LAST : idx - 2'd1;

  // Blend weights
  assign w_sel  = near_1g ? gcf_pkg::W_NEAR_1G : gcf_pkg::W_DEFAULT;
  assign w_rest = gcf_pkg::ONE_Q30 - w_sel;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      gcf_pkg::S_RATE_M: begin
        mul_a = {gyro[idx][31], gyro[idx]};
        mul_b = gcf_pkg::DEG2RAD_Q32;
      end
      gcf_pkg::S_ANG_M: begin
        mul_a = {{2{ang[idx][30]}}, ang[idx]};
        mul_b = {9'b0, dt};
      end
      gcf_pkg::S_CR1_M: begin
        mul_a = {{2{ang[idx_j][30]}}, ang[idx_j]};
        mul_b = {est[idx_k][31], est[idx_k]};
      end
      gcf_pkg::S_CR2_M: begin
        mul_a = {{2{ang[idx_k][30]}}, ang[idx_k]};
        mul_b = {est[idx_j][31], est[idx_j]};
      end
      gcf_pkg::S_SQ_M: begin
        mul_a = work[idx][32:0];
        mul_b = work[idx][32:0];
      end
      gcf_pkg::S_BL1_M: begin
        mul_a = {2'b0, w_sel};
        mul_b = {pred[idx][31], pred[idx]};
      end
      gcf_pkg::S_BL2_M: begin
        mul_a = {2'b0, w_rest};
        mul_b = {unit_a[idx][31], unit_a[idx]};
      end
      gcf_pkg::S_VM: begin
        mul_a = {acc_in[idx][31], acc_in[idx]};
        mul_b = {est[idx][31], est[idx]};
      end
      default: ;
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // Some component beyond +/-2^31
  always_comb begin
    v_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (work[i] > gcf_pkg::LIM31_POS || work[i] < gcf_pkg::LIM31_NEG) v_big = 1'b1;
    end
  end

  // Square root step: two radicand bits per cycle
  assign sq_rem_t     = {sq_rem, sq_n[63:62]};
  assign sq_trial_sub = {2'b0, sq_root, 2'b01};
  assign sq_take      = (sq_rem_t >= sq_trial_sub);

  // Divider step: one quotient bit per cycle
  assign dv_rem_t = {dv_rem, dv_dsh[30]};
  assign dv_take  = (dv_rem_t >= {2'b0, sq_root});

  assign abs_src   = work[idx][32:0];
  assign dv_mag    = abs_src[32] ? 32'(-abs_src) : abs_src[31:0];
  assign dv_result = (sq_root == '0) ? '0
                   : (dv_neg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q}));

  assign cross_diff = acc - prod;
  assign cross_sh   = cross_diff >>> 20;
  assign blend_sum  = acc + prod;
  assign vert_wide  = (acc >>> 16) - $signed({35'b0, grav_mag});

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gcf_pkg::S_IDLE:     if (in_valid) state_next = gcf_pkg::S_RATE_M;
      gcf_pkg::S_RATE_M:   state_next = gcf_pkg::S_RATE_A;
      gcf_pkg::S_RATE_A:   state_next = gcf_pkg::S_ANG_M;
      gcf_pkg::S_ANG_M:    state_next = gcf_pkg::S_ANG_A;
      gcf_pkg::S_ANG_A:
        state_next = (idx == gcf_pkg::IDX_LAST) ? gcf_pkg::S_CR1_M : gcf_pkg::S_RATE_M;
      gcf_pkg::S_CR1_M:    state_next = gcf_pkg::S_CR1_A;
      gcf_pkg::S_CR1_A:    state_next = gcf_pkg::S_CR2_M;
      gcf_pkg::S_CR2_M:    state_next = gcf_pkg::S_CR2_A;
      gcf_pkg::S_CR2_A:
        state_next = (idx == gcf_pkg::IDX_LAST) ? gcf_pkg::S_NSHIFT : gcf_pkg::S_CR1_M;
      gcf_pkg::S_NSHIFT:   if (!v_big) state_next = gcf_pkg::S_SQ_M;
      gcf_pkg::S_SQ_M:     state_next = gcf_pkg::S_SQ_A;
      gcf_pkg::S_SQ_A:
        state_next = (idx == gcf_pkg::IDX_LAST) ? gcf_pkg::S_CHECK : gcf_pkg::S_SQ_M;
      gcf_pkg::S_CHECK: begin
        if (mode == gcf_pkg::NM_ACCEL) begin
          state_next = (acc > gcf_pkg::TENTH_SQ_Q32) ? gcf_pkg::S_SQRT : gcf_pkg::S_NSHIFT;
        end else begin
          state_next = (big || acc > gcf_pkg::TENTH_SQ_Q60) ? gcf_pkg::S_SQRT
                                                          : gcf_pkg::S_NDONE;
        end
      end
      gcf_pkg::S_SQRT:     if (cnt == gcf_pkg::SQRT_LAST) state_next = gcf_pkg::S_DIV_INIT;
      gcf_pkg::S_DIV_INIT: state_next = gcf_pkg::S_DIV;
      gcf_pkg::S_DIV:      if (cnt == gcf_pkg::DIV_LAST) state_next = gcf_pkg::S_DIV_END;
      gcf_pkg::S_DIV_END:
        state_next = (idx == gcf_pkg::IDX_LAST) ? gcf_pkg::S_NDONE : gcf_pkg::S_DIV_INIT;
      gcf_pkg::S_NDONE: begin
        unique case (mode)
          gcf_pkg::NM_PRED:  state_next = gcf_pkg::S_NSHIFT;
          gcf_pkg::NM_ACCEL: state_next = gcf_pkg::S_BL1_M;
          default:           state_next = gcf_pkg::S_VM;
        endcase
      end
      gcf_pkg::S_BL1_M:    state_next = gcf_pkg::S_BL1_A;
      gcf_pkg::S_BL1_A:    state_next = gcf_pkg::S_BL2_M;
      gcf_pkg::S_BL2_M:    state_next = gcf_pkg::S_BL2_A;
      gcf_pkg::S_BL2_A:
        state_next = (idx == gcf_pkg::IDX_LAST) ? gcf_pkg::S_NSHIFT : gcf_pkg::S_BL1_M;
      gcf_pkg::S_VM:       state_next = gcf_pkg::S_VA;
      gcf_pkg::S_VA:
        state_next = (idx == gcf_pkg::IDX_LAST) ? gcf_pkg::S_OUT : gcf_pkg::S_VM;
      gcf_pkg::S_OUT:      if (out_free) state_next = gcf_pkg::S_IDLE;
      default:             state_next = gcf_pkg::S_IDLE;
    endcase
  end

  // Control registers and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      cnt       <= '0;
      mode      <= gcf_pkg::NM_PRED;
      big       <= 1'b0;
    end else begin
      // set on load, clear on accept
      if (state == gcf_pkg::S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        gcf_pkg::S_IDLE: idx <= '0;
        gcf_pkg::S_ANG_A, gcf_pkg::S_SQ_A, gcf_pkg::S_DIV_END, gcf_pkg::S_VA:
          idx <= (idx == gcf_pkg::IDX_LAST) ? 2'd0 : idx + 2'd1;
        gcf_pkg::S_CR2_A, gcf_pkg::S_BL2_A: begin
          if (idx == gcf_pkg::IDX_LAST) begin
            idx  <= '0;
            big  <= 1'b0;
            mode <= (state == gcf_pkg::S_CR2_A) ? gcf_pkg::NM_PRED : gcf_pkg::NM_BLEND;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        gcf_pkg::S_NSHIFT: if (v_big) big <= 1'b1;
        gcf_pkg::S_CHECK: begin
          cnt <= '0;
          if (mode == gcf_pkg::NM_ACCEL && acc <= gcf_pkg::TENTH_SQ_Q32) begin
            mode <= gcf_pkg::NM_BLEND;
            big  <= 1'b0;
          end
        end
        gcf_pkg::S_SQRT, gcf_pkg::S_DIV: cnt <= cnt + 5'd1;
        gcf_pkg::S_DIV_INIT: cnt <= '0;
        gcf_pkg::S_NDONE: begin
          idx <= '0;
          if (mode == gcf_pkg::NM_PRED) begin
            mode <= gcf_pkg::NM_ACCEL;
            big  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration registers and estimate
  always_ff @(posedge clk) begin
    if (rst) begin
      init_x   <= '0;
      init_y   <= '0;
      init_z   <= 32'sd1073741824;
      grav_mag <= 31'd642689;
      est[0]   <= '0;
      est[1]   <= '0;
      est[2]   <= 32'sd1073741824;
    end else if (cfg_wr) begin
      unique case (gcf_pkg::reg_idx_t'(paddr[3:2]))
        gcf_pkg::REG_INIT_X: begin
          init_x <= pwdata;
          est[0] <= pwdata;
        end
        gcf_pkg::REG_INIT_Y: begin
          init_y <= pwdata;
          est[1] <= pwdata;
        end
        gcf_pkg::REG_INIT_Z: begin
          init_z <= pwdata;
          est[2] <= pwdata;
        end
        gcf_pkg::REG_GRAV_MAG: grav_mag <= pwdata[30:0];
        default: ;
      endcase
    end else if (state == gcf_pkg::S_NDONE && mode == gcf_pkg::NM_BLEND) begin
      for (int i = 0; i < 3; i++) est[i] <= gcf_pkg::sat32(66'(work[i]));
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= mul_full;
    case (state)
      gcf_pkg::S_IDLE: begin
        acc_in[0] <= accel_x;
        acc_in[1] <= accel_y;
        acc_in[2] <= accel_z;
        gyro[0]   <= gyro_x;
        gyro[1]   <= gyro_y;
        gyro[2]   <= gyro_z;
        dt        <= time_step;
      end
      gcf_pkg::S_RATE_A: ang[idx] <= prod[62:32];
      gcf_pkg::S_ANG_A:  ang[idx] <= prod[50:20];
      gcf_pkg::S_CR1_A, gcf_pkg::S_BL1_A: acc <= prod;
      gcf_pkg::S_CR2_A:
        work[idx] <= {{12{est[idx][31]}}, est[idx]} - cross_sh[43:0];
      gcf_pkg::S_NSHIFT: begin
        acc <= '0;
        if (v_big) begin
          for (int i = 0; i < 3; i++) work[i] <= work[i] >>> 1;
        end
      end
      gcf_pkg::S_SQ_A: acc <= acc + prod;
      gcf_pkg::S_CHECK: begin
        sq_n    <= acc[63:0];
        sq_rem  <= '0;
        sq_root <= '0;
        if (mode == gcf_pkg::NM_ACCEL) begin
          near_1g <= (acc > gcf_pkg::EIGHT_SQ_Q32) && (acc < gcf_pkg::TWELVE_SQ_Q32);
          // small accel: the prediction goes on alone
          if (acc <= gcf_pkg::TENTH_SQ_Q32) begin
            for (int i = 0; i < 3; i++) work[i] <= {{12{pred[i][31]}}, pred[i]};
          end
        end
      end
      gcf_pkg::S_SQRT: begin
        sq_n    <= {sq_n[61:0], 2'b00};
        sq_rem  <= sq_take ? 34'(sq_rem_t - sq_trial_sub) : sq_rem_t[33:0];
        sq_root <= {sq_root[30:0], sq_take};
      end
      gcf_pkg::S_DIV_INIT: begin
        dv_neg <= abs_src[32];
        dv_rem <= {2'b0, dv_mag[31:1]};
        dv_dsh <= {dv_mag[0], 30'b0};
        dv_q   <= '0;
      end
      gcf_pkg::S_DIV: begin
        dv_rem <= dv_take ? 33'(dv_rem_t - {2'b0, sq_root}) : dv_rem_t[32:0];
        dv_dsh <= {dv_dsh[29:0], 1'b0};
        dv_q   <= {dv_q[29:0], dv_take};
      end
      gcf_pkg::S_DIV_END: work[idx] <= {{12{dv_result[31]}}, dv_result};
      gcf_pkg::S_NDONE: begin
        acc <= '0;
        if (mode == gcf_pkg::NM_PRED) begin
          for (int i = 0; i < 3; i++) begin
            pred[i] <= work[i][31:0];
            work[i] <= {{12{acc_in[i][31]}}, acc_in[i]};
          end
        end else if (mode == gcf_pkg::NM_ACCEL) begin
          for (int i = 0; i < 3; i++) unit_a[i] <= work[i][31:0];
        end
      end
      gcf_pkg::S_BL2_A: work[idx] <= {{8{blend_sum[65]}}, blend_sum[65:30]};
      gcf_pkg::S_VA:    acc <= acc + (prod >>> 14);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == gcf_pkg::S_OUT && out_free) begin
      est_x          <= est[0];
      est_y          <= est[1];
      est_z          <= est[2];
      vertical_accel <= gcf_pkg::sat32(vert_wide);
    end
  end

  // Checks
  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == gcf_pkg::S_IDLE)
    else $error("input taken outside idle");
  a_rose_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == gcf_pkg::S_OUT)
    else $error("result raised outside output state");
  a_sq_fits: assert property (@(posedge clk) disable iff (rst)
    state == gcf_pkg::S_SQ_M |-> !v_big)
    else $error("square taken of an unreduced component");
  a_quot_unit: assert property (@(posedge clk) disable iff (rst)
    state == gcf_pkg::S_DIV_END |-> dv_q <= 31'd1073741824)
    else $error("unit component beyond 1.0");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd3)
    else $error("component index out of range");

endmodule

FILE: dv/gravity_complementary_filter_test.sv
// Testbench for gravity_complementary_filter: directed and random sensor requests
// checked against a bit-exact predictor held in a small scoreboard class.
// Depends on gcf_pkg and the gravity_complementary_filter RTL.
`timescale 1ns / 100ps

module gravity_complementary_filter_test;

  localparam longint DEG_TO_RAD = 64'sd74961321;
  localparam longint UNIT_Q30   = 64'sd1073741824;
  localparam longint WEIGHT_1G  = 64'sd1020054733;
  localparam longint WEIGHT_DEF = 64'sd1052266988;
  localparam longint LIMIT_31   = 64'sd2147483648;
  localparam longint TENTH_Q60  = 64'sd11529215046068469;
  localparam longint TENTH_Q32  = 64'sd42949672;
  localparam longint EIGHT_Q32  = 64'sd274877906944;
  localparam longint TWELVE_Q32 = 64'sd618475290624;

  typedef struct packed {
    logic signed [31:0] ex, ey, ez, vert;
  } estimate_t;

  typedef struct {
    logic signed [31:0] ax, ay, az, gx, gy, gz;
    logic [23:0] dt;
  } sample_t;

  // Predictor plus queue of expected filter outputs
  class filter_scoreboard;
    longint est[3];
    longint grav_mag;
    estimate_t pending[$];
    int errors;

    function new();
      est[0] = 0; est[1] = 0; est[2] = UNIT_Q30;
      grav_mag = 642689;
      errors = 0;
    endfunction

    function void write_reg(gcf_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        gcf_pkg::REG_INIT_X: est[0] = longint'($signed(val));
        gcf_pkg::REG_INIT_Y: est[1] = longint'($signed(val));
        gcf_pkg::REG_INIT_Z: est[2] = longint'($signed(val));
        gcf_pkg::REG_GRAV_MAG: grav_mag = longint'(val[30:0]);
        default: ;
      endcase
    endfunction

    function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function automatic bit too_big(longint v[3]);
      for (int i = 0; i < 3; i++)
        if (v[i] > LIMIT_31 || v[i] < -LIMIT_31) return 1;
      return 0;
    endfunction

    function automatic longint unsigned sq_sum(longint v[3]);
      return longint'(v[0] * v[0]) + longint'(v[1] * v[1]) + longint'(v[2] * v[2]);
    endfunction

    function automatic bit above_tenth(longint v[3]);
      longint unsigned s;
      if (too_big(v)) return 1;
      s = sq_sum(v);
      return s > longint'(TENTH_Q60);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Direction of v in Q2.30, after shifting it into 32-bit range
    function automatic void normalize(longint v[3], output longint u[3]);
      longint w[3];
      longint m;
      w = v;
      while (too_big(w))
        for (int i = 0; i < 3; i++) w[i] = w[i] >>> 1;
      m = longint'(int_sqrt(sq_sum(w)));
      for (int i = 0; i < 3; i++) u[i] = (m != 0) ? (w[i] * UNIT_Q30) / m : 0;
    endfunction

    function void note_sample(sample_t s);
      longint a[3], ang[3], e[3], p[3], u[3], b[3], t[3];
      longint g[3];
      longint unsigned mag;
      longint wt, dot, vert;
      estimate_t r;
      a[0] = longint'(s.ax); a[1] = longint'(s.ay); a[2] = longint'(s.az);
      g[0] = longint'(s.gx); g[1] = longint'(s.gy); g[2] = longint'(s.gz);
      for (int i = 0; i < 3; i++)
        ang[i] = (((g[i] * DEG_TO_RAD) >>> 32) * longint'(s.dt)) >>> 20;
      e = est;
      // small-angle rotation
      p[0] = e[0] - ((ang[1] * e[2] - ang[2] * e[1]) >>> 20);
      p[1] = e[1] - ((ang[2] * e[0] - ang[0] * e[2]) >>> 20);
      p[2] = e[2] - ((ang[0] * e[1] - ang[1] * e[0]) >>> 20);
      if (above_tenth(p)) begin
        normalize(p, t);
        p = t;
      end
      // blend with accel direction unless accel is tiny
      mag = sq_sum(a);
      if (mag > longint'(TENTH_Q32)) begin
        wt = (mag > longint'(EIGHT_Q32) && mag < longint'(TWELVE_Q32)) ?
             WEIGHT_1G : WEIGHT_DEF;
        normalize(a, u);
        for (int i = 0; i < 3; i++) b[i] = (wt * p[i] + (UNIT_Q30 - wt) * u[i]) >>> 30;
      end else begin
        b = p;
      end
      if (above_tenth(b)) begin
        normalize(b, t);
        b = t;
      end
      for (int i = 0; i < 3; i++) est[i] = clamp32(b[i]);
      dot = 0;
      for (int i = 0; i < 3; i++) dot += (a[i] * est[i]) >>> 14;
      vert = (dot >>> 16) - grav_mag;
      r.ex = 32'(est[0]); r.ey = 32'(est[1]); r.ez = 32'(est[2]);
      r.vert = 32'(clamp32(vert));
      pending.push_back(r);
    endfunction

    function void check_result(estimate_t got);
      estimate_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.ex !== want.ex) begin
        $display("%0t: est_x expected %0d got %0d", $time, want.ex, got.ex);
        errors++;
      end
      if (got.ey !== want.ey) begin
        $display("%0t: est_y expected %0d got %0d", $time, want.ey, got.ey);
        errors++;
      end
      if (got.ez !== want.ez) begin
        $display("%0t: est_z expected %0d got %0d", $time, want.ez, got.ez);
        errors++;
      end
      if (got.vert !== want.vert) begin
        $display("%0t: vertical_accel expected %0d got %0d", $time, want.vert,
                 got.vert);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic signed [31:0] accel_x = 0, accel_y = 0, accel_z = 0;
  logic signed [31:0] gyro_x = 0, gyro_y = 0, gyro_z = 0;
  logic [23:0] time_step = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] est_x, est_y, est_z, vertical_accel;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  int send_idle = 0, recv_idle = 0;
  filter_scoreboard board;

  gravity_complementary_filter DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Receiver: random stall, check on accept
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result({est_x, est_y, est_z, vertical_accel});
  end
  always @(negedge clk) out_stall <= (rst == 0) && ($urandom_range(99) < recv_idle);

  task automatic write_register(gcf_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.write_reg(idx, val);
  endtask

  task automatic send_request(sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
    gyro_x <= s.gx; gyro_y <= s.gy; gyro_z <= s.gz;
    time_step <= s.dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(s);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(1310720)) - 32'sd655360;
      default: return $urandom;
    endcase
  endfunction

  // Realistic accel near 1 g, or arbitrary
  function automatic sample_t rand_sample();
    sample_t s;
    if ($urandom_range(9) < 7) begin
      s.ax = $signed($urandom_range(262144)) - 32'sd131072;
      s.ay = $signed($urandom_range(262144)) - 32'sd131072;
      s.az = 32'sd642689 + $signed($urandom_range(131072)) - 32'sd65536;
      s.gx = $signed($urandom_range(13107200)) - 32'sd6553600;
      s.gy = $signed($urandom_range(13107200)) - 32'sd6553600;
      s.gz = $signed($urandom_range(13107200)) - 32'sd6553600;
      s.dt = 24'($urandom_range(33554));
    end else begin
      s.ax = rand_word(); s.ay = rand_word(); s.az = rand_word();
      s.gx = rand_word(); s.gy = rand_word(); s.gz = rand_word();
      s.dt = ($urandom_range(3) == 0) ? 24'hffffff : 24'($urandom);
    end
    return s;
  endfunction

  function automatic sample_t make(int ax, int ay, int az, int gx, int gy, int gz,
                                   int dt);
    sample_t s;
    s.ax = ax; s.ay = ay; s.az = az; s.gx = gx; s.gy = gy; s.gz = gz;
    s.dt = dt[23:0];
    return s;
  endfunction

  initial begin
    #2000000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 0;

    // Directed: tiny, 1 g, near-edge magnitudes, extremes
    send_request(make(0, 0, 0, 0, 0, 0, 0));
    send_request(make(0, 0, 642689, 0, 0, 0, 16777));
    send_request(make(0, 0, 20000, 6553600, 0, 0, 16777));
    send_request(make(524288, 0, 0, 0, 0, 0, 16777));
    send_request(make(786431, 0, 0, 0, 0, 0, 16777));
    send_request(make(786432, 0, 0, 0, 0, 0, 16777));
    send_request(make(524289, 0, 0, 0, 0, 0, 16777));
    send_request(make(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 24'hffffff));
    send_request(make(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000, 24'hffffff));
    send_request(make(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 0,
                      32'h80000000, 24'hffffff));
    drain();
    // Tiny estimate keeps prediction and blend unnormalized
    write_register(gcf_pkg::REG_INIT_X, 32'd1000);
    write_register(gcf_pkg::REG_INIT_Y, 32'hfffffc18);
    write_register(gcf_pkg::REG_INIT_Z, 32'd0);
    write_register(gcf_pkg::REG_GRAV_MAG, 32'hffffffff);
    send_request(make(0, 0, 1000, 0, 0, 0, 0));
    send_request(make(0, 0, 0, 65536, 0, 0, 1000));
    drain();
    write_register(gcf_pkg::REG_INIT_X, 32'h80000000);
    write_register(gcf_pkg::REG_INIT_Y, 32'h7fffffff);
    write_register(gcf_pkg::REG_INIT_Z, 32'h80000000);
    write_register(gcf_pkg::REG_GRAV_MAG, 32'd0);
    send_request(make(100000, -100000, 600000, 3276800, -3276800, 65536, 16777));
    send_request(make(1, 0, 0, 0, 0, 0, 0));
    drain();
    write_register(gcf_pkg::REG_INIT_X, 32'd0);
    write_register(gcf_pkg::REG_INIT_Y, 32'd0);
    write_register(gcf_pkg::REG_INIT_Z, 32'h40000000);
    write_register(gcf_pkg::REG_GRAV_MAG, 32'd642689);

    // Random phases with differing backpressure
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 6 : (ph == 1) ? 78 : 0;
      recv_idle = (ph == 0) ? 78 : (ph == 1) ? 6 : 0;
      for (int n = 0; n < 380; n++) send_request(rand_sample());
      drain();
      write_register(gcf_pkg::REG_GRAV_MAG, $urandom);
      write_register(gcf_pkg::reg_idx_t'($urandom_range(2)), rand_word());
    end
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
